[rtl/lsc_pkg.sv]
// Shared types, constants and helper functions of the line segment clipper.
`timescale 1ns / 1ps
package lsc_pkg;

  // Coordinate width and the number of clip passes built into the pipeline.
  localparam int COORD_WIDTH     = 16;
  localparam int MAX_CLIP_PASSES = 4;
  localparam int CW              = COORD_WIDTH;

  // Outcode bit positions.
  localparam int BIT_LEFT   = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_BOTTOM = 2;
  localparam int BIT_TOP    = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  // Window reset values.
  localparam int RESET_LEFT   = 150;
  localparam int RESET_TOP    = 100;
  localparam int RESET_RIGHT  = 450;
  localparam int RESET_BOTTOM = 300;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   wide_t;
  typedef logic [CW-1:0]        mag_t;
  typedef logic [3:0]           code_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } win_t;

  // Segment state that travels down the pipeline.
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    code_t  c1;
    code_t  c2;
    logic   done;
    logic   acc;
  } seg_t;

  // Crossing computation state for one clip pass.
  typedef struct packed {
    logic   vert;
    logic   sel2;
    logic   neg;
    coord_t edge_val;
    mag_t   lim;
    mag_t   ud;
    mag_t   rem;
    mag_t   low;
    mag_t   q;
  } div_t;

  typedef struct packed {
    seg_t seg;
    div_t dv;
  } work_t;

  function automatic code_t outcode(coord_t x, coord_t y, win_t w);
    code_t c;
    c = '0;
    c[BIT_LEFT]   = (x < w.left);
    c[BIT_RIGHT]  = (x > w.right);
    c[BIT_TOP]    = (y < w.top);
    c[BIT_BOTTOM] = (y > w.bottom);
    return c;
  endfunction

  function automatic wide_t sx(coord_t v);
    return wide_t'({v[CW-1], v});
  endfunction

  function automatic mag_t magn(wide_t v);
    logic [CW:0] t;
    t = v[CW] ? (~v + 1'b1) : v;
    return t[CW-1:0];
  endfunction

endpackage

[rtl/lsc_seg_if.sv]
// Input channel carrying one line segment per item.
`timescale 1ns / 1ps
interface lsc_seg_if;
  logic                  valid;
  logic                  ready;
  lsc_pkg::coord_t       start_x;
  lsc_pkg::coord_t       start_y;
  lsc_pkg::coord_t       end_x;
  lsc_pkg::coord_t       end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

[rtl/lsc_clip_if.sv]
// Output channel carrying one clip result per item.
`timescale 1ns / 1ps
interface lsc_clip_if;
  logic                  valid;
  logic                  ready;
  logic                  visible;
  lsc_pkg::coord_t       clipped_start_x;
  lsc_pkg::coord_t       clipped_start_y;
  lsc_pkg::coord_t       clipped_end_x;
  lsc_pkg::coord_t       clipped_end_y;

  modport source(output valid, visible, clipped_start_x, clipped_start_y,
                 clipped_end_x, clipped_end_y, input ready);
  modport sink(input valid, visible, clipped_start_x, clipped_start_y,
               clipped_end_x, clipped_end_y, output ready);
endinterface

[rtl/line_segment_clipper.sv]
// Cohen-Sutherland line clipper: window registers, clip pass pipeline, output.
// Each pass is two setup stages, one divider stage per quotient bit, one update.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, rst high) empties the pipeline and loads the default window.
`timescale 1ns / 1ps
module line_segment_clipper (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [lsc_pkg::CW-1:0]  cfg_data,
  lsc_seg_if.sink                 seg_in,
  lsc_clip_if.source              clip_out
);

  lsc_pkg::win_t win;
  logic          en;
  logic          pv [lsc_pkg::MAX_CLIP_PASSES+1];
  lsc_pkg::seg_t ps [lsc_pkg::MAX_CLIP_PASSES+1];
  lsc_pkg::seg_t entry;
  lsc_pkg::seg_t last;
  logic          acc;

  // Window registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= lsc_pkg::coord_t'(lsc_pkg::RESET_LEFT);
      win.top    <= lsc_pkg::coord_t'(lsc_pkg::RESET_TOP);
      win.right  <= lsc_pkg::coord_t'(lsc_pkg::RESET_RIGHT);
      win.bottom <= lsc_pkg::coord_t'(lsc_pkg::RESET_BOTTOM);
    end else if (cfg_we) begin
      case (cfg_index)
        lsc_pkg::REG_LEFT:   win.left   <= cfg_data;
        lsc_pkg::REG_TOP:    win.top    <= cfg_data;
        lsc_pkg::REG_RIGHT:  win.right  <= cfg_data;
        lsc_pkg::REG_BOTTOM: win.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign en           = !clip_out.valid || clip_out.ready;
  assign seg_in.ready = en;

  // Entry: initial outcodes.
  always_comb begin
    entry    = '0;
    entry.x1 = seg_in.start_x;
    entry.y1 = seg_in.start_y;
    entry.x2 = seg_in.end_x;
    entry.y2 = seg_in.end_y;
    entry.c1 = lsc_pkg::outcode(seg_in.start_x, seg_in.start_y, win);
    entry.c2 = lsc_pkg::outcode(seg_in.end_x, seg_in.end_y, win);
  end

  assign pv[0] = seg_in.valid;
  assign ps[0] = entry;

  for (genvar p = 0; p < lsc_pkg::MAX_CLIP_PASSES; p++) begin : g_pass
    lsc_pass u_pass (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pv[p]),
      .in_seg    (ps[p]),
      .win       (win),
      .out_valid (pv[p+1]),
      .out_seg   (ps[p+1])
    );
  end

  // After the last pass only a trivial accept remains possible.
  assign last = ps[lsc_pkg::MAX_CLIP_PASSES];
  assign acc  = last.done ? last.acc : (last.c1 == '0 && last.c2 == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_out.valid <= 1'b0;
    end else if (en) begin
      clip_out.valid <= pv[lsc_pkg::MAX_CLIP_PASSES];
    end
    if (en) begin
      clip_out.visible         <= acc;
      clip_out.clipped_start_x <= acc ? last.x1 : '0;
      clip_out.clipped_start_y <= acc ? last.y1 : '0;
      clip_out.clipped_end_x   <= acc ? last.x2 : '0;
      clip_out.clipped_end_y   <= acc ? last.y2 : '0;
    end
  end

endmodule

[rtl/lsc_pass_setup.sv]
// Clip pass front end: accept/reject test, edge choice, then the product.
`timescale 1ns / 1ps
module lsc_pass_setup (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lsc_pkg::seg_t  in_seg,
  input  lsc_pkg::win_t  win,
  output logic           out_valid,
  output lsc_pkg::work_t out_work
);

  typedef struct packed {
    lsc_pkg::seg_t   seg;
    logic            vert;
    logic            sel2;
    logic            neg;
    lsc_pkg::coord_t edge_val;
    lsc_pkg::mag_t   ua;
    lsc_pkg::mag_t   un;
    lsc_pkg::mag_t   ud;
  } pre_t;

  pre_t                  pre_next;
  pre_t                  pre;
  logic                  pre_valid;
  lsc_pkg::code_t        co;
  lsc_pkg::wide_t        a;
  lsc_pkg::wide_t        n;
  lsc_pkg::wide_t        d;
  logic [2*lsc_pkg::CW-1:0] prod;

  // Decide what this pass does and form the operands of the crossing.
  always_comb begin
    pre_next      = '0;
    pre_next.seg  = in_seg;
    co            = (in_seg.c1 != '0) ? in_seg.c1 : in_seg.c2;
    pre_next.sel2 = (in_seg.c1 == '0);
    pre_next.vert = co[lsc_pkg::BIT_TOP] | co[lsc_pkg::BIT_BOTTOM];
    if (pre_next.vert) begin
      pre_next.edge_val = co[lsc_pkg::BIT_TOP] ? win.top : win.bottom;
      a = lsc_pkg::sx(in_seg.x2) - lsc_pkg::sx(in_seg.x1);
      n = lsc_pkg::sx(pre_next.edge_val) - lsc_pkg::sx(in_seg.y1);
      d = lsc_pkg::sx(in_seg.y2) - lsc_pkg::sx(in_seg.y1);
    end else begin
      pre_next.edge_val = co[lsc_pkg::BIT_RIGHT] ? win.right : win.left;
      a = lsc_pkg::sx(in_seg.y2) - lsc_pkg::sx(in_seg.y1);
      n = lsc_pkg::sx(pre_next.edge_val) - lsc_pkg::sx(in_seg.x1);
      d = lsc_pkg::sx(in_seg.x2) - lsc_pkg::sx(in_seg.x1);
    end
    pre_next.neg = a[lsc_pkg::CW] ^ n[lsc_pkg::CW] ^ d[lsc_pkg::CW];
    pre_next.ua  = lsc_pkg::magn(a);
    pre_next.un  = lsc_pkg::magn(n);
    pre_next.ud  = lsc_pkg::magn(d);
    if (!in_seg.done) begin
      if (in_seg.c1 == '0 && in_seg.c2 == '0) begin
        pre_next.seg.done = 1'b1;
        pre_next.seg.acc  = 1'b1;
      end else if ((in_seg.c1 & in_seg.c2) != '0) begin
        pre_next.seg.done = 1'b1;
      end else if (d == '0) begin
        pre_next.seg.done = 1'b1;
      end
    end
  end

  // First register stage holds the operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (en) begin
      pre_valid <= in_valid;
    end
    if (en) begin
      pre <= pre_next;
    end
  end

  assign prod = pre.ua * pre.un;

  // Second register stage holds the product, split for the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pre_valid;
    end
    if (en) begin
      out_work.seg         <= pre.seg;
      out_work.dv.vert     <= pre.vert;
      out_work.dv.sel2     <= pre.sel2;
      out_work.dv.neg      <= pre.neg;
      out_work.dv.edge_val <= pre.edge_val;
      out_work.dv.lim      <= pre.ua;
      out_work.dv.ud       <= pre.ud;
      out_work.dv.rem      <= prod[2*lsc_pkg::CW-1:lsc_pkg::CW];
      out_work.dv.low      <= prod[lsc_pkg::CW-1:0];
      out_work.dv.q        <= '0;
    end
  end

endmodule

[rtl/lsc_div_stage.sv]
// One restoring division step: one quotient bit per register stage.
`timescale 1ns / 1ps
module lsc_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lsc_pkg::work_t in_work,
  output logic           out_valid,
  output lsc_pkg::work_t out_work
);

  lsc_pkg::work_t      work_next;
  logic [lsc_pkg::CW:0] r;
  logic [lsc_pkg::CW:0] diff;
  logic                 qbit;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  always_comb begin
    work_next = in_work;
    r         = {in_work.dv.rem, in_work.dv.low[lsc_pkg::CW-1]};
    diff      = r - {1'b0, in_work.dv.ud};
    qbit      = (r >= {1'b0, in_work.dv.ud});
    work_next.dv.rem = qbit ? diff[lsc_pkg::CW-1:0] : r[lsc_pkg::CW-1:0];
    work_next.dv.low = {in_work.dv.low[lsc_pkg::CW-2:0], 1'b0};
    work_next.dv.q   = {in_work.dv.q[lsc_pkg::CW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_work <= work_next;
    end
  end

endmodule

[rtl/lsc_pass_update.sv]
// Clip pass back end: apply the crossing and recompute the outcode.
`timescale 1ns / 1ps
module lsc_pass_update (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lsc_pkg::work_t in_work,
  input  lsc_pkg::win_t  win,
  output logic           out_valid,
  output lsc_pkg::seg_t  out_seg
);

  lsc_pkg::seg_t   seg_next;
  lsc_pkg::mag_t   qc;
  lsc_pkg::wide_t  qs;
  lsc_pkg::wide_t  sum;
  lsc_pkg::coord_t newc;
  lsc_pkg::coord_t nx;
  lsc_pkg::coord_t ny;

  // Base plus signed, clamped quotient gives the crossing coordinate.
  always_comb begin
    seg_next = in_work.seg;
    qc   = (in_work.dv.q > in_work.dv.lim) ? in_work.dv.lim : in_work.dv.q;
    qs   = lsc_pkg::wide_t'({1'b0, qc});
    if (in_work.dv.neg) begin
      qs = -qs;
    end
    sum  = (in_work.dv.vert ? lsc_pkg::sx(in_work.seg.x1) : lsc_pkg::sx(in_work.seg.y1))
           + qs;
    newc = sum[lsc_pkg::CW-1:0];
    nx   = in_work.dv.vert ? newc : in_work.dv.edge_val;
    ny   = in_work.dv.vert ? in_work.dv.edge_val : newc;
    if (!in_work.seg.done) begin
      if (in_work.dv.sel2) begin
        seg_next.x2 = nx;
        seg_next.y2 = ny;
        seg_next.c2 = lsc_pkg::outcode(nx, ny, win);
      end else begin
        seg_next.x1 = nx;
        seg_next.y1 = ny;
        seg_next.c1 = lsc_pkg::outcode(nx, ny, win);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_seg <= seg_next;
    end
  end

endmodule

[rtl/lsc_pass.sv]
// One full clip pass: setup, pipelined divider, endpoint update.
`timescale 1ns / 1ps
module lsc_pass (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  lsc_pkg::seg_t in_seg,
  input  lsc_pkg::win_t win,
  output logic          out_valid,
  output lsc_pkg::seg_t out_seg
);

  logic           vld [lsc_pkg::CW+1];
  lsc_pkg::work_t wrk [lsc_pkg::CW+1];

  lsc_pass_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_seg    (in_seg),
    .win       (win),
    .out_valid (vld[0]),
    .out_work  (wrk[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < lsc_pkg::CW; i++) begin : g_div
    lsc_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[i]),
      .in_work   (wrk[i]),
      .out_valid (vld[i+1]),
      .out_work  (wrk[i+1])
    );
  end

  lsc_pass_update u_update (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[lsc_pkg::CW]),
    .in_work   (wrk[lsc_pkg::CW]),
    .win       (win),
    .out_valid (out_valid),
    .out_seg   (out_seg)
  );

endmodule

[rtl/lsc_checker.sv]
// Port-level checks of the line clipper and their binding to the top level.
`timescale 1ns / 1ps
module lsc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   visible,
  input logic [lsc_pkg::CW-1:0] sx0,
  input logic [lsc_pkg::CW-1:0] sy0,
  input logic [lsc_pkg::CW-1:0] ex0,
  input logic [lsc_pkg::CW-1:0] ey0
);

  // A waiting result stays valid, with its visible flag and start x unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(sx0))
    else $error("result changed while stalled");

  // Rejected segments report zero endpoints.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> sx0 == '0 && sy0 == '0 && ex0 == '0 && ey0 == '0)
    else $error("rejected result carries nonzero endpoints");

  // Input side is ready exactly when the output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output flow");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (seg_in.ready),
  .out_valid (clip_out.valid),
  .out_ready (clip_out.ready),
  .visible   (clip_out.visible),
  .sx0       (clip_out.clipped_start_x),
  .sy0       (clip_out.clipped_start_y),
  .ex0       (clip_out.clipped_end_x),
  .ey0       (clip_out.clipped_end_y)
);
